// ===== rtl/core/swqf_pkg.sv =====
package swqf_pkg;

  localparam int unsigned DefaultWindow   = 16;
  localparam int unsigned DefaultChannels = 3;
  localparam int unsigned MaxChannels     = 3;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned OutW     = 32;
  localparam int unsigned CoefW    = 36;
  localparam int unsigned AccW     = 64;
  localparam int unsigned TW       = 48;
  localparam int unsigned RateW    = 32;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgSampleRate  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgDerivOrder  = CfgIdxW'(1);
  localparam logic [RateW-1:0]   RateReset      = RateW'(65536);

  typedef enum logic [1:0] {
    ORD_POS,
    ORD_VEL,
    ORD_ACC,
    ORD_ZERO
  } deriv_order_e;

  typedef enum logic [1:0] {
    CK_POS,
    CK_VEL,
    CK_ACC
  } coef_kind_e;

  typedef enum logic [2:0] {
    OP_POS,
    OP_P16,
    OP_VEL,
    OP_ACC,
    OP_T
  } scale_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAPS,
    S_DRAIN,
    S_GO,
    S_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic      acc_clr;
    logic      acc_en;
    logic      sc_start;
    scale_op_e op;
  } lane_ctrl_t;

  // restoring division to q.32, rounded half away from zero
  function automatic logic signed [63:0] rdiv(logic signed [63:0] num, logic [63:0] den);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] r;
    logic [63:0] q;
    neg = num[63];
    mag = neg ? 64'(-num) : 64'(num);
    r   = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], mag[i]};
      q = {q[62:0], 1'b0};
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    for (int i = 0; i < 32; i++) begin
      r = {r[62:0], 1'b0};
      q = {q[62:0], 1'b0};
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    if ({r[62:0], 1'b0} >= den) begin
      q = q + 64'd1;
    end
    return neg ? -$signed(q) : $signed(q);
  endfunction

  // fit coefficient for tap k, centred variable u = 2k - (window - 1)
  function automatic logic signed [CoefW-1:0] coef_at(int unsigned window, int unsigned k,
                                                      coef_kind_e kind);
    longint             u2;
    longint             u4;
    longint             d;
    longint             u;
    longint             s;
    longint             c;
    logic signed [63:0] res;
    u2 = 0;
    u4 = 0;
    for (int unsigned j = 0; j < window; j++) begin
      u  = 2 * longint'(j) - longint'(window) + 1;
      u2 = u2 + u * u;
      u4 = u4 + u * u * u * u;
    end
    d = longint'(window) * u4 - u2 * u2;
    u = 2 * longint'(k) - longint'(window) + 1;
    s = u * u;
    c = longint'(window) * s - u2;
    case (kind)
      CK_POS:  res = rdiv(u4 - u2 * s + c, 64'(d)) + rdiv(u, 64'(u2));
      CK_VEL:  res = rdiv(2 * u, 64'(u2)) + rdiv(4 * c, 64'(d));
      default: res = rdiv(8 * c, 64'(d));
    endcase
    return res[CoefW-1:0];
  endfunction

endpackage

// ===== rtl/core/swqf_if.sv =====
interface swqf_in_if;
  import swqf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample_ch0;
  logic signed [SampleW-1:0] sample_ch1;
  logic signed [SampleW-1:0] sample_ch2;

  modport source (output valid, output sample_ch0, output sample_ch1, output sample_ch2,
                  input ready);
  modport sink (input valid, input sample_ch0, input sample_ch1, input sample_ch2,
                output ready);
endinterface

interface swqf_out_if;
  import swqf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] position_ch0;
  logic signed [OutW-1:0] position_ch1;
  logic signed [OutW-1:0] position_ch2;
  logic signed [OutW-1:0] deriv_ch0;
  logic signed [OutW-1:0] deriv_ch1;
  logic signed [OutW-1:0] deriv_ch2;
  logic                   warming;

  modport source (output valid, output position_ch0, output position_ch1,
                  output position_ch2, output deriv_ch0, output deriv_ch1, output deriv_ch2,
                  output warming, input ready);
  modport sink (input valid, input position_ch0, input position_ch1, input position_ch2,
                input deriv_ch0, input deriv_ch1, input deriv_ch2, input warming,
                output ready);
endinterface

interface swqf_cfg_if;
  import swqf_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/sliding_window_quadratic_fit_top.sv =====
// sliding-window quadratic fit over up to three sample channels
//
// channels: sample_i takes one sample vector per request, result_o returns one
// result per request, cfg_i writes sample_rate (index 0) and derivative_order
// (index 1); cfg_i is always ready, and the user must write it only while the
// block is idle, which the block does not check. all use valid/ready, a request
// moves on a clock edge with both high.
// while the window fills, or when sample_rate is zero, the result is loaded
// into the output register on the accept edge and is valid in the next cycle.
// a full window is walked tap by tap through multiply-accumulate (one ring
// memory read per tap, all channels in parallel), then rescaled in passes of
// the shared per-lane 32x32 multiplier: two passes for position and velocity
// orders, three for acceleration, one for the zero order; then the output
// register is loaded. the next vector can be taken in the cycle the result
// turns valid.
//
// reset empties the window (no clearing pass), sets sample_rate to 1.0 and
// the order to velocity. when result_o stalls, the finished result waits in
// the output register; the next vector is taken once that register frees.
module sliding_window_quadratic_fit_top import swqf_pkg::*; #(
  parameter int unsigned Window   = DefaultWindow,
  parameter int unsigned Channels = DefaultChannels
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  swqf_cfg_if.sink          cfg_i,
  swqf_in_if.sink           sample_i,
  swqf_out_if.source        result_o
);

  localparam int unsigned PtrW  = $clog2(Window);
  localparam int unsigned DataW = Channels * SampleW;
  localparam logic [PtrW-1:0] LastTap = PtrW'(Window - 1);

  state_e                   state_q, state_d;
  logic [RateW-1:0]         rate_q;
  deriv_order_e             order_q;
  logic [PtrW-1:0]          wptr_q, fill_q, rptr_q, tap_q;
  logic                     v1_q, v2_q;
  scale_op_e                op_q, op_next;
  logic                     has_next;

  logic                     ovalid_q;
  logic signed [OutW-1:0]   opos_q [MaxChannels];
  logic signed [OutW-1:0]   oder_q [MaxChannels];
  logic                     owarm_q;

  logic signed [SampleW-1:0] smp [MaxChannels];
  logic [DataW-1:0]         wdata;
  logic [DataW-1:0]         rdata;
  logic signed [CoefW-1:0]  coef_pos, coef_der;
  logic signed [OutW-1:0]   lane_pos [MaxChannels];
  logic signed [OutW-1:0]   lane_der [MaxChannels];
  logic                     lane_done [MaxChannels];
  lane_ctrl_t               lane_ctrl;

  logic                     in_acc, out_acc, rate_zero, warm, store, start_calc;
  logic                     imm_load, calc_load, out_free;
  logic [PtrW-1:0]          wptr_inc, rptr_inc;

  assign smp[0] = sample_i.sample_ch0;
  assign smp[1] = sample_i.sample_ch1;
  assign smp[2] = sample_i.sample_ch2;

  assign in_acc     = sample_i.valid && sample_i.ready;
  assign out_acc    = result_o.valid && result_o.ready;
  assign out_free   = !ovalid_q || result_o.ready;
  assign rate_zero  = rate_q == '0;
  assign warm       = fill_q < LastTap;
  assign store      = in_acc && !rate_zero;
  assign start_calc = store && !warm;
  assign imm_load   = in_acc && (rate_zero || warm);
  assign calc_load  = (state_q == S_OUT) && out_free;
  assign wptr_inc   = (wptr_q == LastTap) ? '0 : wptr_q + PtrW'(1);
  assign rptr_inc   = (rptr_q == LastTap) ? '0 : rptr_q + PtrW'(1);

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RateReset;
      order_q <= ORD_VEL;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CfgSampleRate) begin
        rate_q <= cfg_i.data[RateW-1:0];
      end else if (cfg_i.index == CfgDerivOrder) begin
        order_q <= deriv_order_e'(cfg_i.data[1:0]);
      end
    end
  end

  // follow-up rescale pass after the current one
  always_comb begin
    has_next = 1'b0;
    op_next  = OP_POS;
    case (op_q)
      OP_POS: begin
        case (order_q)
          ORD_POS: begin
            has_next = 1'b1;
            op_next  = OP_P16;
          end
          ORD_VEL: begin
            has_next = 1'b1;
            op_next  = OP_VEL;
          end
          ORD_ACC: begin
            has_next = 1'b1;
            op_next  = OP_ACC;
          end
          default: ;
        endcase
      end
      OP_ACC: begin
        has_next = 1'b1;
        op_next  = OP_T;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start_calc) state_d = S_TAPS;
      S_TAPS:  if (tap_q == LastTap) state_d = S_DRAIN;
      S_DRAIN: if (!v1_q && !v2_q) state_d = S_GO;
      S_GO:    state_d = S_WAIT;
      S_WAIT:  if (lane_done[0]) state_d = has_next ? S_GO : S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    sample_i.ready     = (state_q == S_IDLE) && out_free;
    lane_ctrl.acc_clr  = start_calc;
    lane_ctrl.acc_en   = v2_q;
    lane_ctrl.sc_start = state_q == S_GO;
    lane_ctrl.op       = op_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wptr_q   <= '0;
      fill_q   <= '0;
      rptr_q   <= '0;
      tap_q    <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      op_q     <= OP_POS;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= state_q == S_TAPS;
      v2_q    <= v1_q;
      if (store) begin
        wptr_q <= wptr_inc;
        if (warm) begin
          fill_q <= fill_q + PtrW'(1);
        end
      end
      if (start_calc) begin
        // oldest entry sits just after the one being written
        rptr_q <= wptr_inc;
        tap_q  <= '0;
        op_q   <= OP_POS;
      end else if (state_q == S_TAPS) begin
        rptr_q <= rptr_inc;
        tap_q  <= tap_q + PtrW'(1);
      end else if (state_q == S_WAIT && lane_done[0] && has_next) begin
        op_q <= op_next;
      end
      if (imm_load || calc_load) begin
        ovalid_q <= 1'b1;
      end else if (out_acc) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (imm_load) begin
      owarm_q <= !rate_zero;
      for (int c = 0; c < MaxChannels; c++) begin
        opos_q[c] <= (rate_zero || c >= Channels) ? '0 : OutW'(smp[c]);
        oder_q[c] <= '0;
      end
    end else if (calc_load) begin
      owarm_q <= 1'b0;
      for (int c = 0; c < MaxChannels; c++) begin
        opos_q[c] <= lane_pos[c];
        oder_q[c] <= lane_der[c];
      end
    end
  end

  assign result_o.valid        = ovalid_q;
  assign result_o.position_ch0 = opos_q[0];
  assign result_o.position_ch1 = opos_q[1];
  assign result_o.position_ch2 = opos_q[2];
  assign result_o.deriv_ch0    = oder_q[0];
  assign result_o.deriv_ch1    = oder_q[1];
  assign result_o.deriv_ch2    = oder_q[2];
  assign result_o.warming      = owarm_q;

  // sample ring; writes happen only in idle, and only the reads made while walking taps are accumulated
  for (genvar c = 0; c < Channels; c++) begin : g_wdata
    assign wdata[c*SampleW +: SampleW] = smp[c];
  end

  swqf_window_mem #(
    .Window   (Window),
    .Channels (Channels)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (wptr_q),
    .wdata_i (wdata),
    .raddr_i (rptr_q),
    .rdata_o (rdata)
  );

  swqf_coef_rom #(
    .Window (Window)
  ) u_rom (
    .clk_i     (clk_i),
    .tap_i     (tap_q),
    .acc_sel_i (order_q == ORD_ACC),
    .pos_o     (coef_pos),
    .der_o     (coef_der)
  );

  for (genvar c = 0; c < MaxChannels; c++) begin : g_lane
    if (c < Channels) begin : g_used
      swqf_lane u_lane (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (lane_ctrl),
        .x_i        (rdata[c*SampleW +: SampleW]),
        .coef_pos_i (coef_pos),
        .coef_der_i (coef_der),
        .rate_i     (rate_q),
        .pos_o      (lane_pos[c]),
        .der_o      (lane_der[c]),
        .done_o     (lane_done[c])
      );
    end else begin : g_unused
      assign lane_pos[c]  = '0;
      assign lane_der[c]  = '0;
      assign lane_done[c] = 1'b0;
    end
  end

endmodule

// ===== rtl/core/swqf_window_mem.sv =====
module swqf_window_mem import swqf_pkg::*; #(
  parameter int unsigned Window   = DefaultWindow,
  parameter int unsigned Channels = DefaultChannels,
  localparam int unsigned AddrW   = $clog2(Window),
  localparam int unsigned DataW   = Channels * SampleW
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Window];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/swqf_coef_rom.sv =====
module swqf_coef_rom import swqf_pkg::*; #(
  parameter int unsigned Window = DefaultWindow,
  localparam int unsigned TapW  = $clog2(Window)
) (
  input  logic                    clk_i,
  input  logic [TapW-1:0]         tap_i,
  input  logic                    acc_sel_i,
  output logic signed [CoefW-1:0] pos_o,
  output logic signed [CoefW-1:0] der_o
);

  logic signed [CoefW-1:0] pos_tab [Window];
  logic signed [CoefW-1:0] vel_tab [Window];
  logic signed [CoefW-1:0] acc_tab [Window];
  logic signed [CoefW-1:0] pos_q;
  logic signed [CoefW-1:0] der_q;

  for (genvar k = 0; k < Window; k++) begin : g_tab
    assign pos_tab[k] = coef_at(Window, k, CK_POS);
    assign vel_tab[k] = coef_at(Window, k, CK_VEL);
    assign acc_tab[k] = coef_at(Window, k, CK_ACC);
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_tab[tap_i];
    der_q <= acc_sel_i ? acc_tab[tap_i] : vel_tab[tap_i];
  end

  assign pos_o = pos_q;
  assign der_o = der_q;

endmodule

// ===== rtl/core/swqf_scale.sv =====
module swqf_scale import swqf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [AccW-1:0] a_i,
  input  logic [RateW-1:0]       b_i,
  input  logic                   sh16_i,
  input  logic                   lim47_i,
  output logic                   done_o,
  output logic signed [TW-1:0]   res_o
);

  logic              neg_q;
  logic              sh16_q;
  logic              lim47_q;
  logic [AccW-1:0]   mag_q;
  logic [RateW-1:0]  b_q;
  logic [3:0]        st_q;
  logic              done_q;
  logic [31:0]       mul_a;
  logic [63:0]       prod;
  logic [63:0]       p0_q;
  logic [63:0]       p1_q;
  logic [95:0]       rnd;
  logic [95:0]       sum_q;
  logic [79:0]       q_sh;
  logic [79:0]       lim;
  logic [79:0]       mag_res;
  logic              sat;
  logic signed [TW-1:0] res_d;
  logic signed [TW-1:0] res_q;

  // one 32x32 multiplier, low half then high half
  assign mul_a = st_q[0] ? mag_q[31:0] : mag_q[63:32];
  assign prod  = mul_a * b_q;
  assign rnd   = sh16_q ? (96'd1 << 15) : (96'd1 << 31);

  assign q_sh    = sh16_q ? sum_q[95:16] : {16'd0, sum_q[95:32]};
  assign lim     = lim47_q ? (80'd1 << 47) : (80'd1 << 31);
  assign sat     = q_sh >= lim;
  assign mag_res = sat ? (neg_q ? lim : lim - 80'd1) : q_sh;
  assign res_d   = neg_q ? TW'(-mag_res) : TW'(mag_res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= {st_q[2:0], start_i};
      done_q <= st_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q   <= a_i[AccW-1];
      mag_q   <= a_i[AccW-1] ? AccW'(-a_i) : AccW'(a_i);
      b_q     <= b_i;
      sh16_q  <= sh16_i;
      lim47_q <= lim47_i;
    end
    if (st_q[0]) begin
      p0_q <= prod;
    end
    if (st_q[1]) begin
      p1_q <= prod;
    end
    if (st_q[2]) begin
      sum_q <= {32'd0, p0_q} + {p1_q, 32'd0} + rnd;
    end
    if (st_q[3]) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/core/swqf_lane.sv =====
module swqf_lane import swqf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctrl_t              ctrl_i,
  input  logic signed [SampleW-1:0] x_i,
  input  logic signed [CoefW-1:0] coef_pos_i,
  input  logic signed [CoefW-1:0] coef_der_i,
  input  logic [RateW-1:0]        rate_i,
  output logic signed [OutW-1:0]  pos_o,
  output logic signed [OutW-1:0]  der_o,
  output logic                    done_o
);

  localparam int unsigned ProdW = SampleW + CoefW;

  logic signed [ProdW-1:0] prod_p_q;
  logic signed [ProdW-1:0] prod_d_q;
  logic signed [AccW-1:0]  acc_p_q;
  logic signed [AccW-1:0]  acc_d_q;
  logic signed [TW-1:0]    t_q;
  logic signed [OutW-1:0]  pos_q;
  logic signed [OutW-1:0]  der_q;
  scale_op_e               op_q;
  logic signed [AccW-1:0]  sc_a;
  logic [RateW-1:0]        sc_b;
  logic                    sc_sh16;
  logic                    sc_lim47;
  logic                    sc_done;
  logic signed [TW-1:0]    sc_res;

  always_comb begin
    sc_a     = acc_p_q;
    sc_b     = RateW'(1);
    sc_sh16  = 1'b0;
    sc_lim47 = 1'b0;
    case (ctrl_i.op)
      OP_POS: ;
      OP_P16: sc_sh16 = 1'b1;
      OP_VEL: begin
        sc_a = acc_d_q;
        sc_b = rate_i;
      end
      OP_ACC: begin
        sc_a     = acc_d_q;
        sc_b     = rate_i;
        sc_lim47 = 1'b1;
      end
      OP_T: begin
        sc_a    = AccW'(t_q);
        sc_b    = rate_i;
        sc_sh16 = 1'b1;
      end
      default: ;
    endcase
  end

  swqf_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.sc_start),
    .a_i     (sc_a),
    .b_i     (sc_b),
    .sh16_i  (sc_sh16),
    .lim47_i (sc_lim47),
    .done_o  (sc_done),
    .res_o   (sc_res)
  );

  always_ff @(posedge clk_i) begin
    prod_p_q <= x_i * coef_pos_i;
    prod_d_q <= x_i * coef_der_i;
    if (ctrl_i.acc_clr) begin
      acc_p_q <= '0;
      acc_d_q <= '0;
      der_q   <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_p_q <= acc_p_q + AccW'(prod_p_q);
      acc_d_q <= acc_d_q + AccW'(prod_d_q);
    end
    if (ctrl_i.sc_start) begin
      op_q <= ctrl_i.op;
    end
    if (sc_done) begin
      case (op_q)
        OP_POS:  pos_q <= sc_res[OutW-1:0];
        OP_ACC:  t_q   <= sc_res;
        default: der_q <= sc_res[OutW-1:0];
      endcase
    end
  end

  assign pos_o  = pos_q;
  assign der_o  = der_q;
  assign done_o = sc_done;

endmodule

// ===== rtl/core/swqf_checker.sv =====
module swqf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] pos0_i,
  input logic [31:0] pos1_i,
  input logic [31:0] pos2_i,
  input logic [31:0] der0_i,
  input logic [31:0] der1_i,
  input logic [31:0] der2_i,
  input logic        warming_i
);

  logic [1:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({pos0_i, pos1_i, pos2_i, der0_i, der1_i, der2_i, warming_i}))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without a pending request");

  a_one_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q < 2'd2)
    else $error("more than one request outstanding");

  a_warm_deriv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && warming_i |-> der0_i == '0 && der1_i == '0 && der2_i == '0)
    else $error("nonzero derivative while warming");

endmodule

bind sliding_window_quadratic_fit_top swqf_checker u_swqf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .pos0_i      (result_o.position_ch0),
  .pos1_i      (result_o.position_ch1),
  .pos2_i      (result_o.position_ch2),
  .der0_i      (result_o.deriv_ch0),
  .der1_i      (result_o.deriv_ch1),
  .der2_i      (result_o.deriv_ch2),
  .warming_i   (result_o.warming)
);

// ===== sim/tb_sliding_window_quadratic_fit_top.sv =====
`timescale 1ns / 100ps

module tb_sliding_window_quadratic_fit_top;
  import swqf_pkg::*;

  localparam int unsigned Win = DefaultWindow;
  localparam int unsigned Chn = DefaultChannels;
  localparam int unsigned NumSettings = 12;
  localparam int unsigned ItemsPerSetting = 95;

  typedef struct packed {
    logic [2:0][OutW-1:0] pos;
    logic [2:0][OutW-1:0] der;
    logic                 warm;
  } fit_result_t;

  logic clk;
  logic rst_n;

  swqf_cfg_if cfg_ch ();
  swqf_in_if  in_ch ();
  swqf_out_if res_ch ();

  sliding_window_quadratic_fit_top dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_i    (cfg_ch),
    .sample_i (in_ch),
    .result_o (res_ch)
  );

  // own copy of the fit state and registers
  longint       coef_pos [Win];
  longint       coef_vel [Win];
  longint       coef_acc [Win];
  logic signed [SampleW-1:0] ring [Win][Chn];
  int unsigned  ring_wr;
  int unsigned  ring_fill;
  logic [RateW-1:0] rate_q;
  deriv_order_e     order_q;

  fit_result_t  fit_queue [$];
  bit           typed_mode;
  bit           failed;
  int unsigned  snd_idle;
  int unsigned  rcv_idle;
  int unsigned  n_items;

  // num * 2^32 / den, rounded half away from zero
  function automatic longint q32_div(longint num, longint den);
    logic [127:0] m;
    logic [127:0] q;
    logic [127:0] r;
    m = (num < 0) ? 128'(-num) : 128'(num);
    m = m << 32;
    q = m / 128'(den);
    r = m % 128'(den);
    if (2 * r >= 128'(den)) q = q + 1;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // round(a * b / 2^sh) half away from zero, clamped to [-lim, lim-1]
  function automatic longint mul_round_sat(longint a, logic [31:0] b, int sh, longint lim);
    logic [127:0] m;
    logic [127:0] q;
    m = (a < 0) ? (128'(~a) + 128'd1) : 128'(a);
    q = (m * 128'(b) + (128'd1 << (sh - 1))) >> sh;
    if (a < 0) return (q >= 128'(lim)) ? -lim : -longint'(q);
    return (q >= 128'(lim)) ? lim - 1 : longint'(q);
  endfunction

  task automatic build_coefs();
    longint u2;
    longint u4;
    longint d;
    longint u;
    longint c;
    u2 = 0;
    u4 = 0;
    for (int k = 0; k < Win; k++) begin
      u  = 2 * longint'(k) - longint'(Win) + 1;
      u2 += u * u;
      u4 += u * u * u * u;
    end
    d = longint'(Win) * u4 - u2 * u2;
    for (int k = 0; k < Win; k++) begin
      u = 2 * longint'(k) - longint'(Win) + 1;
      c = longint'(Win) * u * u - u2;
      coef_pos[k] = q32_div(u4 - u2 * u * u + c, d) + q32_div(u, u2);
      coef_vel[k] = q32_div(2 * u, u2) + q32_div(4 * c, d);
      coef_acc[k] = q32_div(8 * c, d);
    end
  endtask

  function automatic fit_result_t fit_step(logic signed [SampleW-1:0] s [Chn]);
    fit_result_t r;
    longint p;
    longint v;
    longint a;
    longint x;
    longint t;
    longint der;
    r = '0;
    if (rate_q == '0) return r;
    for (int c = 0; c < Chn; c++) ring[ring_wr][c] = s[c];
    if (ring_fill < Win - 1) begin
      ring_fill++;
      ring_wr = (ring_wr + 1) % Win;
      for (int c = 0; c < Chn; c++) r.pos[c] = OutW'(longint'(s[c]));
      r.warm = 1'b1;
      return r;
    end
    ring_wr = (ring_wr + 1) % Win;
    for (int c = 0; c < Chn; c++) begin
      p = 0;
      v = 0;
      a = 0;
      for (int j = 0; j < Win; j++) begin
        x = longint'(ring[(ring_wr + j) % Win][c]);
        p += x * coef_pos[j];
        v += x * coef_vel[j];
        a += x * coef_acc[j];
      end
      case (order_q)
        ORD_POS: der = mul_round_sat(p, 32'd1, 16, 64'sd1 << 31);
        ORD_VEL: der = mul_round_sat(v, rate_q, 32, 64'sd1 << 31);
        ORD_ACC: begin
          t   = mul_round_sat(a, rate_q, 32, 64'sd1 << 47);
          der = mul_round_sat(t, rate_q, 16, 64'sd1 << 31);
        end
        default: der = 0;
      endcase
      r.pos[c] = OutW'(mul_round_sat(p, 32'd1, 32, 64'sd1 << 31));
      r.der[c] = OutW'(der);
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // predictor and scoreboard, both sampled at the clock edge
  always @(posedge clk) begin
    logic signed [SampleW-1:0] s [Chn];
    fit_result_t e;
    fit_result_t got;
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == CfgSampleRate) rate_q = cfg_ch.data;
      else if (cfg_ch.index == CfgDerivOrder) order_q = deriv_order_e'(cfg_ch.data[1:0]);
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      s[0] = in_ch.sample_ch0;
      s[1] = in_ch.sample_ch1;
      s[2] = in_ch.sample_ch2;
      e = fit_step(s);
      if (typed_mode) begin
        // window still filling: inputs pass through
        e = '0;
        e.warm = 1'b1;
        e.pos[0] = OutW'(in_ch.sample_ch0);
        e.pos[1] = OutW'(in_ch.sample_ch1);
        e.pos[2] = OutW'(in_ch.sample_ch2);
      end
      fit_queue.push_back(e);
      n_items++;
    end
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got.pos  = {res_ch.position_ch2, res_ch.position_ch1, res_ch.position_ch0};
      got.der  = {res_ch.deriv_ch2, res_ch.deriv_ch1, res_ch.deriv_ch0};
      got.warm = res_ch.warming;
      if (fit_queue.size() == 0) begin
        $error("result with nothing expected");
        failed = 1'b1;
      end else begin
        e = fit_queue.pop_front();
        for (int c = 0; c < Chn; c++) begin
          if (got.pos[c] !== e.pos[c]) begin
            $error("position_ch%0d exp %0d got %0d", c, $signed(e.pos[c]), $signed(got.pos[c]));
            failed = 1'b1;
          end
          if (got.der[c] !== e.der[c]) begin
            $error("deriv_ch%0d exp %0d got %0d", c, $signed(e.der[c]), $signed(got.der[c]));
            failed = 1'b1;
          end
        end
        if (got.warm !== e.warm) begin
          $error("warming exp %0d got %0d", e.warm, got.warm);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= rcv_idle);
  end

  task automatic send_vector(logic signed [SampleW-1:0] a, logic signed [SampleW-1:0] b,
                             logic signed [SampleW-1:0] c);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.sample_ch0 <= a;
    in_ch.sample_ch1 <= b;
    in_ch.sample_ch2 <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (fit_queue.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // smooth per-channel trajectories with occasional noise and extremes
  int trk_val [Chn];
  int trk_vel [Chn];
  int trk_acc [Chn];

  function automatic logic signed [SampleW-1:0] next_sample(int c);
    int mode;
    mode = $urandom_range(19);
    if (mode < 14) begin
      if ($urandom_range(40) == 0) begin
        trk_val[c] = $signed(16'($urandom));
        trk_vel[c] = $signed(10'($urandom));
        trk_acc[c] = $signed(4'($urandom));
      end
      trk_vel[c] += trk_acc[c];
      trk_val[c] += trk_vel[c];
      if (trk_val[c] > 32767 || trk_val[c] < -32768) begin
        trk_val[c] = (trk_val[c] > 0) ? 32767 : -32768;
        trk_vel[c] = -trk_vel[c] / 2;
        trk_acc[c] = -trk_acc[c];
      end
      return SampleW'(trk_val[c]);
    end
    if (mode < 18) return SampleW'($urandom);
    return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
  endfunction

  logic signed [SampleW-1:0] dir_tab [25][3] = '{
    '{16'sh7fff, 16'sh8000, 16'sh0000}, '{16'sh8000, 16'sh7fff, 16'shffff},
    '{16'sh0000, 16'sh0001, 16'sh5555}, '{16'shffff, 16'shaaaa, 16'sh0001},
    '{16'sh1234, 16'shedcb, 16'sh7fff}, '{16'sh0100, 16'sh0200, 16'sh0300},
    '{16'sh0200, 16'sh0400, 16'sh0600}, '{16'sh0300, 16'sh0600, 16'sh0900},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff}, '{16'sh8000, 16'sh8000, 16'sh8000},
    '{16'sh7fff, 16'sh8000, 16'sh7fff}, '{16'sh8000, 16'sh7fff, 16'sh8000},
    '{16'sh0000, 16'sh0000, 16'sh0000}, '{16'sh0f0f, 16'shf0f0, 16'sh3c3c},
    '{16'sh4000, 16'shc000, 16'sh2000}, '{16'sh7fff, 16'sh8000, 16'sh0000},
    '{16'sh7fff, 16'sh8000, 16'sh0000}, '{16'sh8000, 16'sh7fff, 16'sh0000},
    '{16'sh7fff, 16'sh8000, 16'shffff}, '{16'sh8000, 16'sh7fff, 16'sh0001},
    '{16'sh7fff, 16'sh8000, 16'sh7fff}, '{16'sh8000, 16'sh7fff, 16'sh8000},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff}, '{16'sh7fff, 16'sh7fff, 16'sh7fff},
    '{16'sh0000, 16'sh8000, 16'sh7fff}
  };

  initial begin
    logic [RateW-1:0] rates  [NumSettings];
    deriv_order_e     orders [NumSettings];
    rst_n        = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    in_ch.valid  = 1'b0;
    in_ch.sample_ch0 = '0;
    in_ch.sample_ch1 = '0;
    in_ch.sample_ch2 = '0;
    res_ch.ready = 1'b0;
    failed     = 1'b0;
    typed_mode = 1'b0;
    n_items    = 0;
    snd_idle   = 22;
    rcv_idle   = 82;
    ring_wr    = 0;
    ring_fill  = 0;
    rate_q     = RateReset;
    order_q    = ORD_VEL;
    for (int c = 0; c < Chn; c++) begin
      trk_val[c] = 0;
      trk_vel[c] = 3;
      trk_acc[c] = 1;
    end
    build_coefs();
    rates  = '{32'h0001_0000, 32'h0, 32'hffff_ffff, 32'h0001_0000, 32'h1, 32'h0003_8000,
               32'hffff_ffff, 32'h0100_0000, 0, 0, 0, 0};
    orders = '{ORD_POS, ORD_VEL, ORD_ACC, ORD_POS, ORD_VEL, ORD_ZERO, ORD_VEL, ORD_ACC,
               ORD_POS, ORD_POS, ORD_POS, ORD_POS};
    for (int k = 8; k < NumSettings; k++) begin
      rates[k]  = $urandom_range(1) ? $urandom : $urandom_range(32'h0004_0000, 1);
      orders[k] = deriv_order_e'($urandom_range(3));
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, window fill then full-window extremes
    for (int i = 0; i < 25; i++) begin
      typed_mode = (i < Win - 1);
      send_vector(dir_tab[i][0], dir_tab[i][1], dir_tab[i][2]);
    end
    typed_mode = 1'b0;

    for (int k = 0; k < NumSettings; k++) begin
      drain_results();
      write_reg(CfgSampleRate, rates[k]);
      write_reg(CfgDerivOrder, ($urandom & ~32'h3) | 32'(orders[k]));
      write_reg(CfgIdxW'($urandom_range(15, 2)), $urandom);
      for (int i = 0; i < ItemsPerSetting; i++) begin
        if (n_items >= 760) begin
          snd_idle = 0;
          rcv_idle = 0;
        end else if (n_items >= 390) begin
          snd_idle = 82;
          rcv_idle = 22;
        end
        if (k == 6 && i == ItemsPerSetting / 2) drain_results();
        send_vector(next_sample(0), next_sample(1), next_sample(2));
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (fit_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/swqf_pkg.sv
rtl/core/swqf_if.sv
rtl/core/swqf_window_mem.sv
rtl/core/swqf_coef_rom.sv
rtl/core/swqf_scale.sv
rtl/core/swqf_lane.sv
rtl/core/sliding_window_quadratic_fit_top.sv
rtl/core/swqf_checker.sv
sim/tb_sliding_window_quadratic_fit_top.sv
